// ===== sv/tgpa_pkg.sv =====
// ----------------------------------------------------------------------------
// tgpa_pkg: Thai glyph position adjust, shared types and tables
// Glyph codes, shifted glyph tables for both font sets, and the result bundle
// passed from the rule logic to the output buffer.
// ----------------------------------------------------------------------------
package tgpa_pkg;

  localparam int unsigned MaxResults = 3;

  localparam logic [7:0] SaraAm      = 8'hd3;
  localparam logic [7:0] SaraAa      = 8'hd2;
  localparam logic [7:0] Nikhahit    = 8'hed;
  localparam logic [7:0] NikLeftWin  = 8'h99;
  localparam logic [7:0] NikLeftMac  = 8'h8f;
  localparam logic [7:0] ToneFirst   = 8'he8;
  localparam logic [7:0] ToneLast    = 8'hec;
  localparam logic [7:0] LowerFirst  = 8'hd8;
  localparam logic [7:0] LowerLast   = 8'hda;
  localparam logic [7:0] YoYing      = 8'had;
  localparam logic [7:0] DoChada     = 8'hae;
  localparam logic [7:0] ToPatak     = 8'haf;
  localparam logic [7:0] ThoThan     = 8'hb0;
  localparam logic [7:0] YoNoTail    = 8'h90;
  localparam logic [7:0] ThoNoTailWin = 8'h80;
  localparam logic [7:0] ThoNoTailMac = 8'h9f;

  typedef struct packed {
    logic [1:0]                 count;
    logic [MaxResults-1:0][7:0] bytes;
    logic [MaxResults-1:0]      lasts;
  } result_t;

  function automatic logic is_long_tail(input logic [7:0] c);
    return (c == 8'hbb) || (c == 8'hbd) || (c == 8'hbf) || (c == 8'hcc);
  endfunction

  // Upper vowel lookup: bit 3 flags a hit, bits 2:0 give the table index.
  function automatic logic [3:0] above_lookup(input logic [7:0] c);
    logic [3:0] r;
    unique case (c)
      8'hd1:   r = 4'h8;
      8'hd4:   r = 4'h9;
      8'hd5:   r = 4'ha;
      8'hd6:   r = 4'hb;
      8'hd7:   r = 4'hc;
      8'he7:   r = 4'hd;
      8'hed:   r = 4'he;
      default: r = 4'h0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] top_low(input logic [2:0] idx, input logic win);
    logic [7:0] r;
    unique case (idx)
      3'd0:    r = win ? 8'h8b : 8'h88;
      3'd1:    r = win ? 8'h8c : 8'h89;
      3'd2:    r = win ? 8'h8d : 8'h8a;
      3'd3:    r = win ? 8'h8e : 8'h8b;
      default: r = win ? 8'h8f : 8'h8c;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] top_low_left(input logic [2:0] idx, input logic win);
    logic [7:0] r;
    unique case (idx)
      3'd0:    r = win ? 8'h86 : 8'h83;
      3'd1:    r = win ? 8'h87 : 8'h84;
      3'd2:    r = win ? 8'h88 : 8'h85;
      3'd3:    r = win ? 8'h89 : 8'h86;
      default: r = win ? 8'h8a : 8'h87;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] top_left(input logic [2:0] idx, input logic win);
    logic [7:0] r;
    unique case (idx)
      3'd0:    r = win ? 8'h9b : 8'h98;
      3'd1:    r = win ? 8'h9c : 8'h99;
      3'd2:    r = win ? 8'h9d : 8'h9a;
      3'd3:    r = win ? 8'h9e : 8'h9b;
      default: r = win ? 8'h9f : 8'h9c;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] above_left(input logic [2:0] idx, input logic win);
    logic [7:0] r;
    unique case (idx)
      3'd0:    r = win ? 8'h98 : 8'h92;
      3'd1:    r = win ? 8'h81 : 8'h94;
      3'd2:    r = win ? 8'h82 : 8'h95;
      3'd3:    r = win ? 8'h83 : 8'h96;
      3'd4:    r = win ? 8'h84 : 8'h97;
      3'd5:    r = win ? 8'h9a : 8'h93;
      default: r = win ? 8'h99 : 8'h8f;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] below_low(input logic [1:0] idx);
    logic [7:0] r;
    unique case (idx)
      2'd0:    r = 8'hfc;
      2'd1:    r = 8'hfd;
      default: r = 8'hfe;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/tgpa_in_if.sv =====
// ----------------------------------------------------------------------------
// tgpa_in_if: input character channel
// Valid/ready channel carrying one TIS-620 byte and its end-of-string flag.
// ----------------------------------------------------------------------------
interface tgpa_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;

  modport source (output valid, output ch, output last, input ready);
  modport sink   (input valid, input ch, input last, output ready);
endinterface

// ===== sv/tgpa_out_if.sv =====
// ----------------------------------------------------------------------------
// tgpa_out_if: output glyph channel
// Valid/ready channel carrying one adjusted glyph byte and its end flag.
// ----------------------------------------------------------------------------
interface tgpa_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

// ===== sv/tgpa_rules.sv =====
// ----------------------------------------------------------------------------
// tgpa_rules: context state and glyph rewrite rules
// Holds the two previous characters and the held-back byte, and maps one
// character to up to three output bytes in a single step.
// ----------------------------------------------------------------------------
module tgpa_rules (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       ch_i,
  input  logic             last_i,
  input  logic             win_i,
  output tgpa_pkg::result_t result_o
);

  logic [7:0] prev_q, prev_d;
  logic [7:0] prev2_q, prev2_d;
  logic [1:0] pos_q, pos_d;
  logic [7:0] held_q, held_d;
  logic       held_vld_q, held_vld_d;

  logic       has1, has2;
  logic [7:0] nik_left;
  logic       ch_tone, p_tone, p_lower;
  logic [3:0] ch_above, p_above;
  logic [7:0] cur0, held_eff, final_byte;
  logic       two;
  logic [1:0] slot;

  always_comb begin
    has1     = (pos_q != 2'd0);
    has2     = pos_q[1];
    nik_left = win_i ? tgpa_pkg::NikLeftWin : tgpa_pkg::NikLeftMac;
    ch_tone  = (ch_i >= tgpa_pkg::ToneFirst) && (ch_i <= tgpa_pkg::ToneLast);
    p_tone   = (prev_q >= tgpa_pkg::ToneFirst) && (prev_q <= tgpa_pkg::ToneLast);
    p_lower  = (prev_q >= tgpa_pkg::LowerFirst) && (prev_q <= tgpa_pkg::LowerLast);
    ch_above = tgpa_pkg::above_lookup(ch_i);
    p_above  = tgpa_pkg::above_lookup(prev_q);

    cur0     = ch_i;
    held_eff = held_q;
    two      = 1'b0;

    if (ch_i == tgpa_pkg::SaraAm) begin
      two = 1'b1;
      if (!has1) begin
        cur0 = tgpa_pkg::Nikhahit;
      end else if (tgpa_pkg::is_long_tail(prev_q)) begin
        cur0 = nik_left;
      end else if (p_tone) begin
        // Tone over Sara Am: move nikhahit into the held slot
        if (has2) begin
          if (tgpa_pkg::is_long_tail(prev2_q)) begin
            cur0     = tgpa_pkg::top_left(prev_q[2:0], win_i);
            held_eff = nik_left;
          end else begin
            cur0     = prev_q;
            held_eff = tgpa_pkg::Nikhahit;
          end
        end
      end else begin
        cur0 = tgpa_pkg::Nikhahit;
      end
    end else if (ch_tone) begin
      if (has1) begin
        if (tgpa_pkg::is_long_tail(prev_q)) begin
          cur0 = tgpa_pkg::top_low_left(ch_i[2:0], win_i);
        end else if (p_above[3]) begin
          if (has2 && tgpa_pkg::is_long_tail(prev2_q)) begin
            cur0 = tgpa_pkg::top_left(ch_i[2:0], win_i);
          end
        end else if (p_lower) begin
          if (has2) begin
            cur0 = tgpa_pkg::is_long_tail(prev2_q) ?
                   tgpa_pkg::top_low_left(ch_i[2:0], win_i) :
                   tgpa_pkg::top_low(ch_i[2:0], win_i);
          end
        end else begin
          cur0 = tgpa_pkg::top_low(ch_i[2:0], win_i);
        end
      end
    end else if (ch_above[3]) begin
      if (has1 && tgpa_pkg::is_long_tail(prev_q)) begin
        cur0 = tgpa_pkg::above_left(ch_above[2:0], win_i);
      end
    end else if ((ch_i >= tgpa_pkg::LowerFirst) && (ch_i <= tgpa_pkg::LowerLast)) begin
      if (has1) begin
        priority if (prev_q == tgpa_pkg::YoYing) begin
          held_eff = tgpa_pkg::YoNoTail;
        end else if ((prev_q == tgpa_pkg::DoChada) || (prev_q == tgpa_pkg::ToPatak)) begin
          cur0 = tgpa_pkg::below_low(ch_i[1:0]);
        end else if (prev_q == tgpa_pkg::ThoThan) begin
          held_eff = win_i ? tgpa_pkg::ThoNoTailWin : tgpa_pkg::ThoNoTailMac;
        end else begin
          cur0 = ch_i;
        end
      end
    end

    final_byte = two ? tgpa_pkg::SaraAa : cur0;

    // Pack results in emit order: held byte, first of a pair, closing byte
    result_o = '0;
    slot     = 2'd0;
    if (held_vld_q) begin
      result_o.bytes[slot] = held_eff;
      slot                 = slot + 2'd1;
    end
    if (two) begin
      result_o.bytes[slot] = cur0;
      slot                 = slot + 2'd1;
    end
    if (last_i) begin
      result_o.bytes[slot] = final_byte;
      result_o.lasts[slot] = 1'b1;
      slot                 = slot + 2'd1;
    end
    result_o.count = slot;

    if (last_i) begin
      prev_d     = '0;
      prev2_d    = '0;
      pos_d      = '0;
      held_d     = '0;
      held_vld_d = 1'b0;
    end else begin
      prev_d     = ch_i;
      prev2_d    = prev_q;
      pos_d      = (pos_q == 2'd3) ? pos_q : pos_q + 2'd1;
      held_d     = final_byte;
      held_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q     <= '0;
      prev2_q    <= '0;
      pos_q      <= '0;
      held_q     <= '0;
      held_vld_q <= 1'b0;
    end else if (step_i) begin
      prev_q     <= prev_d;
      prev2_q    <= prev2_d;
      pos_q      <= pos_d;
      held_q     <= held_d;
      held_vld_q <= held_vld_d;
    end
  end

endmodule

// ===== sv/tgpa_outbuf.sv =====
// ----------------------------------------------------------------------------
// tgpa_outbuf: result buffer
// Takes up to three result bytes at once and drains them one per cycle while out_o is ready.
// ----------------------------------------------------------------------------
module tgpa_outbuf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  tgpa_pkg::result_t result_i,
  output logic              can_load_o,
  tgpa_out_if.source        out_o
);

  logic [tgpa_pkg::MaxResults-1:0][7:0] byte_q;
  logic [tgpa_pkg::MaxResults-1:0]      last_q;
  logic [1:0]                           cnt_q;
  logic                                 pop;

  assign out_o.valid    = (cnt_q != 2'd0);
  assign out_o.out_byte = byte_q[0];
  assign out_o.out_last = last_q[0];
  assign pop            = out_o.valid && out_o.ready;
  // Room for a new batch when empty, or when the head is the only entry and it leaves now
  assign can_load_o     = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load_i) begin
      cnt_q <= result_i.count;
    end else if (pop) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      byte_q <= result_i.bytes;
      last_q <= result_i.lasts;
    end else if (pop) begin
      byte_q <= {8'h00, byte_q[tgpa_pkg::MaxResults-1:1]};
      last_q <= {1'b0, last_q[tgpa_pkg::MaxResults-1:1]};
    end
  end

endmodule

// ===== sv/thai_glyph_position_adjust.sv =====
// ----------------------------------------------------------------------------
// thai_glyph_position_adjust: TIS-620 to shifted Thai font glyphs
// Rewrites tone marks, upper and lower vowels and some consonants of a Thai
// byte stream into shifted glyph codes of a Windows or Macintosh font.
// ----------------------------------------------------------------------------
//
//   channel    dir  handshake      payload
//   in_i       in   valid/ready    ch[7:0], last
//   out_o      out  valid/ready    out_byte[7:0], out_last
//   glyph_set  in   write enable   glyph_set_i (1 Windows, 0 Macintosh)
//
// An accepted character waits in the input register until the buffer has
// room, then the rule logic turns it into zero to three bytes that load the
// result buffer. The buffer drains one byte per cycle while out_o is ready and
// refills as its last byte leaves; Sara Am and end of string add bytes.
// Reset clears the context, the held byte and all valid flags; glyph set
// resets to Macintosh. A stalled output holds the buffer, which backs up the
// input register and drops in_i.ready.
// ----------------------------------------------------------------------------
module thai_glyph_position_adjust (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        glyph_set_we_i,
  input  logic        glyph_set_i,
  tgpa_in_if.sink     in_i,
  tgpa_out_if.source  out_o
);

  logic              glyph_set_q;
  logic              inq_vld_q, inq_vld_d;
  logic [7:0]        inq_ch_q;
  logic              inq_last_q;
  logic              can_load;
  logic              advance;
  logic              accept;
  tgpa_pkg::result_t result;

  // Glyph set register, to be written only while the stream is idle; the user is bound, the block does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      glyph_set_q <= 1'b0;
    end else if (glyph_set_we_i) begin
      glyph_set_q <= glyph_set_i;
    end
  end

  // Advance the input register into the rules when the buffer has room
  assign advance    = inq_vld_q && can_load;
  assign in_i.ready = !inq_vld_q || can_load;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    inq_vld_d = inq_vld_q;
    if (accept) begin
      inq_vld_d = 1'b1;
    end else if (advance) begin
      inq_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inq_vld_q <= 1'b0;
    end else begin
      inq_vld_q <= inq_vld_d;
    end
  end

  // Capture the transaction payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      inq_ch_q   <= in_i.ch;
      inq_last_q <= in_i.last;
    end
  end

  tgpa_rules u_rules (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .ch_i     (inq_ch_q),
    .last_i   (inq_last_q),
    .win_i    (glyph_set_q),
    .result_o (result)
  );

  tgpa_outbuf u_outbuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (advance),
    .result_i   (result),
    .can_load_o (can_load),
    .out_o      (out_o)
  );

endmodule
